[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the port checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("port check failed");

// next-cycle implication, idle during reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("port check failed");

`endif

[rtl/rdec_pkg.sv]
// ----------------------------------------------------------------------------
// rdec_pkg
// Types, constants and arithmetic helpers for Doppler ego compensation.
// ----------------------------------------------------------------------------
package rdec_pkg;

	localparam int VEL_W     = 16;
	localparam int ANG_W     = 16;
	localparam int ANG_FRAC  = 13;
	localparam int ANG_SH    = 30 - ANG_FRAC;
	localparam int PHI_W     = ANG_W + 2;
	localparam int X_W       = PHI_W + ANG_SH + 1;
	localparam int LEV_W     = 21;
	localparam int SX_W      = ((VEL_W > LEV_W) ? VEL_W : LEV_W) + 1;
	localparam int PROD_W    = SX_W + 32;
	localparam int SUM_W     = PROD_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam int NSTAGE    = 14;
	localparam int ST_TRIG   = 12;

	localparam longint HALF_PI_Q30  = 64'sd1686629713;
	localparam longint HALF_PI_HALF = HALF_PI_Q30 / 2;
	localparam longint ONE_Q30      = 64'sd1073741824;
	localparam longint RND_Q30      = 64'sd536870912;

	localparam int Q_MAX = int'(((64'sd1 <<< ANG_W) <<< ANG_SH) / HALF_PI_Q30) + 2;
	localparam int Q_W   = $clog2(Q_MAX + 1) + 1;

	localparam int K_72 = 38;
	localparam int K_56 = 37;
	localparam int K_42 = 37;
	localparam int K_30 = 36;
	localparam int K_20 = 36;
	localparam int K_12 = 35;
	localparam int K_6  = 34;
	localparam logic [31:0] MAG_72 = 32'(((64'd1 << K_72) + 64'd71) / 64'd72);
	localparam logic [31:0] MAG_56 = 32'(((64'd1 << K_56) + 64'd55) / 64'd56);
	localparam logic [31:0] MAG_42 = 32'(((64'd1 << K_42) + 64'd41) / 64'd42);
	localparam logic [31:0] MAG_30 = 32'(((64'd1 << K_30) + 64'd29) / 64'd30);
	localparam logic [31:0] MAG_20 = 32'(((64'd1 << K_20) + 64'd19) / 64'd20);
	localparam logic [31:0] MAG_12 = 32'(((64'd1 << K_12) + 64'd11) / 64'd12);
	localparam logic [31:0] MAG_6  = 32'(((64'd1 << K_6) + 64'd5) / 64'd6);

	localparam logic [CFG_IDX_W-1:0] REG_EGO_VX    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EGO_VY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_RATE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MOUNT_YAW = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_FLIP = 3'd6;

	typedef logic [NSTAGE:1] adv_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] ego_velocity_x;
		logic signed [VEL_W-1:0] ego_velocity_y;
		logic signed [15:0]      ego_yaw_rate;
		logic signed [15:0]      mount_offset_x;
		logic signed [15:0]      mount_offset_y;
		logic signed [ANG_W-1:0] mount_yaw;
		logic                    mount_roll_flipped;
	} cfg_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] azimuth;
		logic signed [VEL_W-1:0] raw_doppler;
	} det_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] compensated_doppler;
		logic                    saturated;
	} res_t;

	function automatic logic signed [33:0] mul30(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return 34'((p + RND_Q30) >>> 30);
	endfunction

	function automatic logic [30:0] div_const(input logic [30:0] v, input logic [31:0] m,
		input int unsigned k);
		logic [63:0] p;
		p = {33'd0, v} * {32'd0, m};
		return 31'(p >> k);
	endfunction

	function automatic logic signed [LEV_W-1:0] round12(input logic signed [31:0] p);
		logic signed [32:0] t;
		t = 33'(p) + 33'sd2048;
		return LEV_W'(t >>> 12);
	endfunction

	function automatic logic signed [Q_W-1:0] quadrant_of(input logic signed [X_W-1:0] n);
		logic signed [Q_W-1:0] c;
		c = Q_W'(-Q_MAX);
		for (int k = -Q_MAX + 1; k <= Q_MAX; k++) begin
			if (n >= X_W'(longint'(k) * HALF_PI_Q30))
				c = c + Q_W'(1);
		end
		return c;
	endfunction

endpackage

[rtl/rdec_ctrl.sv]
// ----------------------------------------------------------------------------
// rdec_ctrl
// Valid bits and advance enables of the pipeline; bubbles collapse on stall.
// ----------------------------------------------------------------------------
module rdec_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          det_valid,
	output logic          det_stall,
	output logic          res_valid,
	input  logic          res_stall,
	output rdec_pkg::adv_t adv
);
	import rdec_pkg::*;

	adv_t vld_q;

	always_comb begin
		adv[NSTAGE] = !vld_q[NSTAGE] || !res_stall;
		for (int i = NSTAGE - 1; i >= 1; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1])
				vld_q[1] <= det_valid;
			for (int i = 2; i <= NSTAGE; i++) begin
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign det_stall = !adv[1];
	assign res_valid = vld_q[NSTAGE];

endmodule

[rtl/rdec_trig.sv]
// ----------------------------------------------------------------------------
// rdec_trig
// Beam angle, quadrant reduction and sine/cosine polynomials, one product a stage.
// ----------------------------------------------------------------------------
module rdec_trig (
	input  logic               clk,
	input  rdec_pkg::adv_t     adv,
	input  rdec_pkg::cfg_t     cfg,
	input  rdec_pkg::det_t     det,
	output logic signed [31:0] sn_s12,
	output logic signed [31:0] cs_s12
);
	import rdec_pkg::*;

	localparam logic signed [31:0] ONE = 32'(ONE_Q30);

	logic signed [PHI_W-1:0] phi_s1;
	logic signed [X_W-1:0]   x_s2;
	logic signed [Q_W-1:0]   q_s2;
	logic signed [31:0]      r_s3, r_s4, r_s5, r_s6, r_s7, r_s8, r_s9, r_s10, r_s11;
	logic [1:0]              qd_s3, qd_s4, qd_s5, qd_s6, qd_s7, qd_s8, qd_s9, qd_s10, qd_s11;
	logic [30:0]             x2_s4, x2_s5, x2_s6, x2_s7, x2_s8, x2_s9;
	logic [30:0]             ts_s5, tc_s5, ps_s6, pc_s6, ts_s7, tc_s7;
	logic [30:0]             ps_s8, pc_s8, ts_s9, tc_s9, ps_s10, pc_s10, ts_s11;
	logic signed [31:0]      c_s11;

	logic signed [PHI_W-1:0] az_x, phi_c;
	logic signed [X_W-1:0]   x_c, n_c, r_c;
	logic signed [31:0]      x2s;
	logic signed [31:0]      s_c;

	always_comb begin
		az_x  = PHI_W'(det.azimuth);
		phi_c = (cfg.mount_roll_flipped ? -az_x : az_x) + PHI_W'(cfg.mount_yaw);
		x_c   = X_W'(phi_s1) <<< ANG_SH;
		n_c   = x_c + X_W'(HALF_PI_HALF);
		r_c   = x_s2 - X_W'(longint'(q_s2) * HALF_PI_Q30);
		x2s   = $signed({1'b0, x2_s9});
		s_c   = 32'(mul30(r_s11, ONE - $signed({1'b0, ts_s11})));
	end

	always_ff @(posedge clk) begin
		if (adv[1])
			phi_s1 <= phi_c;
		if (adv[2]) begin
			x_s2 <= x_c;
			q_s2 <= quadrant_of(n_c);
		end
		if (adv[3]) begin
			r_s3  <= 32'(r_c);
			qd_s3 <= q_s2[1:0];
		end
		if (adv[4]) begin
			x2_s4 <= 31'(mul30(r_s3, r_s3));
			r_s4  <= r_s3;
			qd_s4 <= qd_s3;
		end
		if (adv[5]) begin
			ts_s5 <= div_const(x2_s4, MAG_72, K_72);
			tc_s5 <= div_const(x2_s4, MAG_56, K_56);
			x2_s5 <= x2_s4;
			r_s5  <= r_s4;
			qd_s5 <= qd_s4;
		end
		if (adv[6]) begin
			ps_s6 <= 31'(mul30($signed({1'b0, x2_s5}), ONE - $signed({1'b0, ts_s5})));
			pc_s6 <= 31'(mul30($signed({1'b0, x2_s5}), ONE - $signed({1'b0, tc_s5})));
			x2_s6 <= x2_s5;
			r_s6  <= r_s5;
			qd_s6 <= qd_s5;
		end
		if (adv[7]) begin
			ts_s7 <= div_const(ps_s6, MAG_42, K_42);
			tc_s7 <= div_const(pc_s6, MAG_30, K_30);
			x2_s7 <= x2_s6;
			r_s7  <= r_s6;
			qd_s7 <= qd_s6;
		end
		if (adv[8]) begin
			ps_s8 <= 31'(mul30($signed({1'b0, x2_s7}), ONE - $signed({1'b0, ts_s7})));
			pc_s8 <= 31'(mul30($signed({1'b0, x2_s7}), ONE - $signed({1'b0, tc_s7})));
			x2_s8 <= x2_s7;
			r_s8  <= r_s7;
			qd_s8 <= qd_s7;
		end
		if (adv[9]) begin
			ts_s9 <= div_const(ps_s8, MAG_20, K_20);
			tc_s9 <= div_const(pc_s8, MAG_12, K_12);
			x2_s9 <= x2_s8;
			r_s9  <= r_s8;
			qd_s9 <= qd_s8;
		end
		if (adv[10]) begin
			ps_s10 <= 31'(mul30(x2s, ONE - $signed({1'b0, ts_s9})));
			pc_s10 <= 31'(mul30(x2s, ONE - $signed({1'b0, tc_s9})));
			r_s10  <= r_s9;
			qd_s10 <= qd_s9;
		end
		if (adv[11]) begin
			ts_s11 <= div_const(ps_s10, MAG_6, K_6);
			c_s11  <= ONE - $signed({2'b00, pc_s10[30:1]});
			r_s11  <= r_s10;
			qd_s11 <= qd_s10;
		end
		if (adv[ST_TRIG]) begin
			case (qd_s11)
				2'd0: begin sn_s12 <= s_c;    cs_s12 <= c_s11;  end
				2'd1: begin sn_s12 <= c_s11;  cs_s12 <= -s_c;   end
				2'd2: begin sn_s12 <= -s_c;   cs_s12 <= -c_s11; end
				default: begin sn_s12 <= -c_s11; cs_s12 <= s_c; end
			endcase
		end
	end

endmodule

[rtl/rdec_lever.sv]
// ----------------------------------------------------------------------------
// rdec_lever
// Ego velocity moved to the mount by the lever arm, delayed to meet the trig path.
// ----------------------------------------------------------------------------
module rdec_lever (
	input  logic                              clk,
	input  rdec_pkg::adv_t                    adv,
	input  rdec_pkg::cfg_t                    cfg,
	input  rdec_pkg::det_t                    det,
	output logic signed [rdec_pkg::SX_W-1:0]  sx_o,
	output logic signed [rdec_pkg::SX_W-1:0]  sy_o,
	output logic signed [rdec_pkg::VEL_W-1:0] raw_o
);
	import rdec_pkg::*;

	logic signed [31:0]      pwy_s1, pwx_s1;
	logic signed [SX_W-1:0]  sx_s [2:ST_TRIG];
	logic signed [SX_W-1:0]  sy_s [2:ST_TRIG];
	logic signed [VEL_W-1:0] raw_s [1:ST_TRIG];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pwy_s1   <= cfg.ego_yaw_rate * cfg.mount_offset_y;
			pwx_s1   <= cfg.ego_yaw_rate * cfg.mount_offset_x;
			raw_s[1] <= det.raw_doppler;
		end
		if (adv[2]) begin
			sx_s[2]  <= SX_W'(cfg.ego_velocity_x) - SX_W'(round12(pwy_s1));
			sy_s[2]  <= SX_W'(cfg.ego_velocity_y) + SX_W'(round12(pwx_s1));
			raw_s[2] <= raw_s[1];
		end
		for (int i = 3; i <= ST_TRIG; i++) begin
			if (adv[i]) begin
				sx_s[i]  <= sx_s[i-1];
				sy_s[i]  <= sy_s[i-1];
				raw_s[i] <= raw_s[i-1];
			end
		end
	end

	assign sx_o  = sx_s[ST_TRIG];
	assign sy_o  = sy_s[ST_TRIG];
	assign raw_o = raw_s[ST_TRIG];

endmodule

[rtl/rdec_proj.sv]
// ----------------------------------------------------------------------------
// rdec_proj
// Projection onto the beam, rounding, raw Doppler add and saturation.
// ----------------------------------------------------------------------------
module rdec_proj (
	input  logic                              clk,
	input  rdec_pkg::adv_t                    adv,
	input  logic signed [rdec_pkg::SX_W-1:0]  sx,
	input  logic signed [rdec_pkg::SX_W-1:0]  sy,
	input  logic signed [rdec_pkg::VEL_W-1:0] raw,
	input  logic signed [31:0]                sn,
	input  logic signed [31:0]                cs,
	output rdec_pkg::res_t                    res
);
	import rdec_pkg::*;

	localparam logic signed [SUM_W-1:0] MAXV = SUM_W'((64'sd1 <<< (VEL_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] MINV = -MAXV - SUM_W'(1);

	logic signed [PROD_W-1:0] a_s13, b_s13;
	logic signed [VEL_W-1:0]  raw_s13;
	res_t                     res_s14;
	logic signed [SUM_W-1:0]  tot, tot_c;
	res_t                     res_c;

	always_comb begin
		tot   = SUM_W'(a_s13) + SUM_W'(b_s13) + SUM_W'(RND_Q30);
		tot_c = (tot >>> 30) + SUM_W'(raw_s13);
		res_c.saturated = 1'b1;
		if (tot_c > MAXV)
			res_c.compensated_doppler = VEL_W'(MAXV);
		else if (tot_c < MINV)
			res_c.compensated_doppler = VEL_W'(MINV);
		else begin
			res_c.compensated_doppler = VEL_W'(tot_c);
			res_c.saturated = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NSTAGE-1]) begin
			a_s13   <= sx * cs;
			b_s13   <= sy * sn;
			raw_s13 <= raw;
		end
		if (adv[NSTAGE])
			res_s14 <= res_c;
	end

	assign res = res_s14;

endmodule

[rtl/radar_doppler_ego_compensation_top.sv]
// ----------------------------------------------------------------------------
// radar_doppler_ego_compensation_top
// Ego-motion compensation of radar Doppler, one detection a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   det channel: one beat per detection (azimuth, raw Doppler), valid/stall.
//   res channel: one beat per detection (compensated Doppler, clip flag).
//   Configuration: wr_en/wr_index/wr_data write the ego and mount registers;
//   write only while no detection is in flight.
//   Depth: 14 register stages from the det beat to the res beat.
//   Throughput: one beat per cycle unless det_stall holds it; the depth is
//   set by the chain of Q30 products in the sine and cosine polynomials,
//   one product per stage.
//   Reset: clears all valid bits and sets every configuration register to zero.
//   Stall on res: the output beat holds, empty stages keep filling, and
//   det_stall rises only once all 14 stages hold a beat.
// ----------------------------------------------------------------------------
module radar_doppler_ego_compensation_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  det_valid,
	output logic                                  det_stall,
	input  rdec_pkg::det_t                        det,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output rdec_pkg::res_t                        res,
	input  logic                                  wr_en,
	input  logic [rdec_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [rdec_pkg::CFG_W-1:0]            wr_data
);
	import rdec_pkg::*;

	cfg_t                    cfg_q;
	adv_t                    adv;
	logic signed [SX_W-1:0]  sx, sy;
	logic signed [VEL_W-1:0] raw;
	logic signed [31:0]      sn, cs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_EGO_VX:    cfg_q.ego_velocity_x     <= VEL_W'(wr_data);
				REG_EGO_VY:    cfg_q.ego_velocity_y     <= VEL_W'(wr_data);
				REG_YAW_RATE:  cfg_q.ego_yaw_rate       <= wr_data;
				REG_OFFSET_X:  cfg_q.mount_offset_x     <= wr_data;
				REG_OFFSET_Y:  cfg_q.mount_offset_y     <= wr_data;
				REG_MOUNT_YAW: cfg_q.mount_yaw          <= wr_data;
				REG_ROLL_FLIP: cfg_q.mount_roll_flipped <= wr_data[0];
				default: ;
			endcase
		end
	end

	rdec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.det_valid (det_valid),
		.det_stall (det_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.adv       (adv)
	);

	rdec_trig u_trig (
		.clk    (clk),
		.adv    (adv),
		.cfg    (cfg_q),
		.det    (det),
		.sn_s12 (sn),
		.cs_s12 (cs)
	);

	rdec_lever u_lever (
		.clk   (clk),
		.adv   (adv),
		.cfg   (cfg_q),
		.det   (det),
		.sx_o  (sx),
		.sy_o  (sy),
		.raw_o (raw)
	);

	rdec_proj u_proj (
		.clk (clk),
		.adv (adv),
		.sx  (sx),
		.sy  (sy),
		.raw (raw),
		.sn  (sn),
		.cs  (cs),
		.res (res)
	);

endmodule

[rtl/rdec_checker.sv]
// ----------------------------------------------------------------------------
// rdec_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdec_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           det_valid,
	input logic           det_stall,
	input logic           res_valid,
	input logic           res_stall,
	input rdec_pkg::res_t res
);
	import rdec_pkg::*;

	logic at_rail;

	assign at_rail = (res.compensated_doppler == {1'b0, {(VEL_W-1){1'b1}}})
		|| (res.compensated_doppler == {1'b1, {(VEL_W-1){1'b0}}});

	`AST_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid)
	`AST_NEXT(a_res_stable, clk, arst_n, res_valid && res_stall, $stable(res))
	`AST_IMPLY(a_full_stall, clk, arst_n, det_stall, res_valid && res_stall)
	`AST_IMPLY(a_sat_rail, clk, arst_n, res_valid && res.saturated, at_rail)

endmodule

bind radar_doppler_ego_compensation_top rdec_checker u_rdec_checker (.*);
